@@ sv/strs_pkg.sv @@
// Shared constants, types and codes for the range-sum segment tree.
package strs_pkg;

  localparam int LOG_LEAVES = 10;
  localparam int LEAVES     = 1 << LOG_LEAVES;
  localparam int NODE_W     = LOG_LEAVES + 1;
  localparam int NODES      = 2 * LEAVES;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 48;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_GET   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADD,
    ST_GET,
    ST_UP_RD,
    ST_UP_SUM,
    ST_Q_LVL,
    ST_Q_A,
    ST_Q_B,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [SUM_W-1:0]  wdata;
    logic [NODE_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] result;
    logic             bad_index;
  } done_t;

endpackage

@@ sv/strs_ram.sv @@
// Node store: one write port, one registered read port.
module strs_ram
  import strs_pkg::*;
(
  input  logic             clk,
  input  ram_req_t         req,
  output logic [SUM_W-1:0] rdata
);

  logic [SUM_W-1:0] mem [0:NODES-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

@@ sv/strs_seq.sv @@
// Sequencer with the shared 48-bit adder that walks the tree for sets, adds and range queries.
module strs_seq
  import strs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [IDX_W-1:0]  index,
  input  logic [IDX_W-1:0]  right_index,
  input  logic [VAL_W-1:0]  value,
  input  logic              out_free,
  output done_t             done,
  output ram_req_t          ram_req,
  input  logic [SUM_W-1:0]  rdata
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  leaf_count;
  logic [NODE_W-1:0] clr_addr, clr_addr_next;
  logic [NODE_W-1:0] node, node_next;
  logic [NODE_W-1:0] bnode, bnode_next;
  logic [SUM_W-1:0]  acc, acc_next;
  logic              bad, bad_next;
  logic              show, show_next;

  logic [CNT_W-1:0]  live;
  logic              pos_ok;
  logic [NODE_W-1:0] leaf_addr;
  logic [CNT_W-1:0]  hi_clamp;
  logic [SUM_W-1:0]  val_ext;
  logic [SUM_W-1:0]  sum;
  logic [NODE_W:0]   a_inc;
  logic [NODE_W-1:0] b_dec;

  assign live      = (leaf_count < CNT_W'(LEAVES)) ? leaf_count : CNT_W'(LEAVES);
  assign pos_ok    = {1'b0, index} < live;
  assign leaf_addr = {1'b1, index};
  assign hi_clamp  = ({1'b0, right_index} >= live) ? (live - 1'b1) : {1'b0, right_index};
  assign val_ext   = {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
  assign sum       = acc + rdata;
  assign a_inc     = {1'b0, node} + 1'b1;
  assign b_dec     = bnode - 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= CNT_W'(LEAVES);
    end else if (cfg_write) begin
      leaf_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    node  <= node_next;
    bnode <= bnode_next;
    acc   <= acc_next;
    bad   <= bad_next;
    show  <= show_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR: begin
        if (&clr_addr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_QUERY) begin
            state_next = (live == '0) ? ST_FIN : ST_Q_LVL;
          end else if (!pos_ok) begin
            state_next = ST_FIN;
          end else begin
            unique case (cmd)
              CMD_SET: state_next = ST_UP_RD;
              CMD_ADD: state_next = ST_ADD;
              default: state_next = ST_GET;
            endcase
          end
        end
      end
      ST_ADD:    state_next = ST_UP_RD;
      ST_GET:    state_next = ST_FIN;
      ST_UP_RD:  state_next = (node == NODE_W'(1)) ? ST_FIN : ST_UP_SUM;
      ST_UP_SUM: state_next = ST_UP_RD;
      ST_Q_LVL: begin
        if (node > bnode)  state_next = ST_FIN;
        else if (node[0])  state_next = ST_Q_A;
        else if (!bnode[0]) state_next = ST_Q_B;
      end
      ST_Q_A:    state_next = bnode[0] ? ST_Q_LVL : ST_Q_B;
      ST_Q_B:    state_next = ST_Q_LVL;
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_addr_next = clr_addr;
    node_next     = node;
    bnode_next    = bnode;
    acc_next      = acc;
    bad_next      = bad;
    show_next     = show;
    ram_req       = '0;
    done          = '0;
    unique case (state)
      ST_CLR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
      end
      ST_IDLE: begin
        node_next     = leaf_addr;
        bnode_next    = NODE_W'(LEAVES) | NODE_W'(hi_clamp[IDX_W-1:0]);
        acc_next      = val_ext;
        bad_next      = 1'b0;
        show_next     = (cmd == CMD_GET) || (cmd == CMD_QUERY);
        ram_req.raddr = leaf_addr;
        if (cmd == CMD_QUERY) begin
          acc_next = '0;
        end else if (!pos_ok) begin
          // reject: leave the store alone, report zero
          acc_next  = '0;
          bad_next  = 1'b1;
          show_next = 1'b0;
        end else if (in_valid && cmd == CMD_SET) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = leaf_addr;
          ram_req.wdata = val_ext;
        end
      end
      ST_ADD: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = node;
        ram_req.wdata = sum;
        acc_next      = sum;
      end
      ST_GET: begin
        acc_next = rdata;
      end
      ST_UP_RD: begin
        ram_req.raddr = node ^ NODE_W'(1);
      end
      ST_UP_SUM: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = node >> 1;
        ram_req.wdata = sum;
        acc_next      = sum;
        node_next     = node >> 1;
      end
      ST_Q_LVL: begin
        if (node[0]) begin
          ram_req.raddr = node;
        end else begin
          ram_req.raddr = bnode;
          if (bnode[0]) begin
            node_next  = node >> 1;
            bnode_next = bnode >> 1;
          end
        end
      end
      ST_Q_A: begin
        acc_next      = sum;
        ram_req.raddr = bnode;
        if (!bnode[0]) begin
          node_next = a_inc[NODE_W-1:0];
        end else begin
          node_next  = a_inc[NODE_W:1];
          bnode_next = bnode >> 1;
        end
      end
      ST_Q_B: begin
        acc_next   = sum;
        bnode_next = {1'b0, b_dec[NODE_W-1:1]};
        node_next  = node >> 1;
      end
      ST_FIN: begin
        done.valid     = out_free;
        done.result    = show ? acc : '0;
        done.bad_index = bad;
      end
      default: begin
        clr_addr_next = '0;
      end
    endcase
  end

endmodule

@@ sv/segment_tree_range_sum.sv @@
// Top level: range-sum segment tree with its node store and output register.
//
// A segment tree of 1024 leaves with 48-bit wrapping sums, kept in a single
// 2048-entry store with one read and one write port. After reset the block
// zeroes the store, one node a cycle; in_stall stays high meanwhile, while
// leaf_count writes are taken as usual. One request is in work at a time and
// the read port sets the pace: a set writes the leaf, then does a sibling
// read and a parent write for each of the 10 levels and a last read state
// at the root; an add reads and rewrites the leaf first; a get reads it; a
// query walks the levels through Q_LVL, Q_A and Q_B; a rejected request or
// a query with no live leaves goes straight to ST_FIN. A new request is
// taken while the last result still waits in the output register.
module segment_tree_range_sum
  import strs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [IDX_W-1:0]  index,
  input  logic [IDX_W-1:0]  right_index,
  input  logic [VAL_W-1:0]  value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SUM_W-1:0]  result,
  output logic              bad_index
);

  ram_req_t         ram_req;
  logic [SUM_W-1:0] rdata;
  done_t            done;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  strs_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  strs_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .index       (index),
    .right_index (right_index),
    .value       (value),
    .out_free    (out_free),
    .done        (done),
    .ram_req     (ram_req),
    .rdata       (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid) begin
      result    <= done.result;
      bad_index <= done.bad_index;
    end
  end

endmodule

@@ sv/strs_checker.sv @@
// Port-level checks for the range-sum segment tree, bound to the top level.
module strs_checker
  import strs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SUM_W-1:0]  result,
  input logic              bad_index
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result) && $stable(bad_index))
    else $error("stalled result changed");

  // a rejected request reports zero
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_index |-> result == '0)
    else $error("rejected request with nonzero result");

  // busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in work");

  // store clearing blocks requests after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("request port open during clearing");

endmodule

bind segment_tree_range_sum strs_checker u_strs_checker (.*);

@@ test/segment_tree_range_sum_tb.sv @@
// Testbench for the range-sum segment tree: directed and random requests checked against a leaf model.
module segment_tree_range_sum_tb;
  import strs_pkg::*;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic             oor;
  } tree_answer_t;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [CNT_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        cmd;
  logic [IDX_W-1:0]  index;
  logic [IDX_W-1:0]  right_index;
  logic [VAL_W-1:0]  value;
  logic              out_valid;
  logic              out_stall;
  logic [SUM_W-1:0]  result;
  logic              bad_index;

  // Leaf-level copy of the tree: every node sum follows from these.
  logic [SUM_W-1:0]  leaf_sums [LEAVES];
  logic [CNT_W-1:0]  leaf_limit;
  tree_answer_t      expected_answers [$];
  tree_answer_t      oldest_answer;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned request_count [4];

  segment_tree_range_sum dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .index        (index),
    .right_index  (right_index),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result       (result),
    .bad_index    (bad_index)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int unsigned live_count();
    return (leaf_limit < LEAVES) ? int'(leaf_limit) : LEAVES;
  endfunction

  task automatic predict_request(cmd_t c, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                                 logic [VAL_W-1:0] v);
    tree_answer_t     ans;
    int unsigned      n;
    int unsigned      top;
    logic [SUM_W-1:0] delta;
    n = live_count();
    delta = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    ans.sum = '0;
    ans.oor = 1'b0;
    if (c == CMD_QUERY) begin
      if (n != 0 && lo <= hi) begin
        // clamp the right bound to the last live leaf
        top = (hi >= n) ? n - 1 : hi;
        for (int k = lo; k <= top; k++) ans.sum += leaf_sums[k];
      end
    end else if (lo >= n) begin
      ans.oor = 1'b1;
    end else begin
      case (c)
        CMD_SET: leaf_sums[lo] = delta;
        CMD_ADD: leaf_sums[lo] = leaf_sums[lo] + delta;
        default: ans.sum = leaf_sums[lo];
      endcase
    end
    expected_answers.push_back(ans);
  endtask

  task automatic send_request(cmd_t c, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                              logic [VAL_W-1:0] v);
    in_valid    <= 1'b1;
    cmd         <= c;
    index       <= lo;
    right_index <= hi;
    value       <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(c, lo, hi, v);
    request_count[c]++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid, then hold until every result is back and the block has settled.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_leaf_count(logic [CNT_W-1:0] count);
    wait_for_results();
    cfg_write  <= 1'b1;
    cfg_data   <= count;
    leaf_limit = count;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic note_mismatch(string what, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (expected_answers.size() == 0) begin
        note_mismatch("unexpected result", '0, result);
      end else begin
        oldest_answer = expected_answers.pop_front();
        checked_count++;
        if (oldest_answer.sum !== result)
          note_mismatch("result", oldest_answer.sum, result);
        if (oldest_answer.oor !== bad_index)
          note_mismatch("bad_index", SUM_W'(oldest_answer.oor), SUM_W'(bad_index));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic test_reset_state();
    send_request(CMD_GET, 10'd0, 10'd0, 32'h0);
    send_request(CMD_GET, 10'd1023, 10'd0, 32'h0);
    send_request(CMD_QUERY, 10'd0, 10'd1023, 32'h0);
  endtask

  task automatic test_point_updates();
    send_request(CMD_SET, 10'd0, 10'd0, 32'h7FFF_FFFF);
    send_request(CMD_SET, 10'd1023, 10'd0, 32'h8000_0000);
    send_request(CMD_ADD, 10'd0, 10'd0, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 10'd1023, 10'd0, 32'h0000_0001);
    send_request(CMD_SET, 10'd512, 10'd0, 32'hFFFF_FFFF);
    send_request(CMD_GET, 10'd0, 10'd0, 32'h0);
    send_request(CMD_GET, 10'd1023, 10'd0, 32'h0);
    send_request(CMD_GET, 10'd512, 10'd0, 32'h0);
    send_request(CMD_QUERY, 10'd0, 10'd1023, 32'h0);
    // empty range: left above right
    send_request(CMD_QUERY, 10'd5, 10'd3, 32'h0);
    send_request(CMD_QUERY, 10'd1023, 10'd1023, 32'h0);
    send_request(CMD_QUERY, 10'd1, 10'd1022, 32'h0);
  endtask

  task automatic test_leaf_count_bounds();
    write_leaf_count(11'd100);
    send_request(CMD_SET, 10'd100, 10'd0, 32'h1234_5678);
    send_request(CMD_ADD, 10'd1023, 10'd0, 32'h1);
    send_request(CMD_GET, 10'd99, 10'd0, 32'h0);
    send_request(CMD_QUERY, 10'd0, 10'd1023, 32'h0);
    // left bound past the clamped right bound
    send_request(CMD_QUERY, 10'd100, 10'd200, 32'h0);
    write_leaf_count(11'd0);
    send_request(CMD_GET, 10'd0, 10'd0, 32'h0);
    send_request(CMD_QUERY, 10'd0, 10'd0, 32'h0);
    write_leaf_count(11'd1);
    send_request(CMD_GET, 10'd1, 10'd0, 32'h0);
    send_request(CMD_QUERY, 10'd0, 10'd1023, 32'h0);
    // count above the tree size acts as full; leaves past a shrink kept their values
    write_leaf_count(11'd2047);
    send_request(CMD_GET, 10'd1023, 10'd0, 32'h0);
    send_request(CMD_QUERY, 10'd0, 10'd1023, 32'h0);
  endtask

  task automatic random_request();
    cmd_t             c;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [VAL_W-1:0] v;
    int unsigned      n;
    int unsigned      pick;
    n = live_count();
    pick = $urandom_range(99);
    if (pick < 25)      c = CMD_SET;
    else if (pick < 50) c = CMD_ADD;
    else if (pick < 70) c = CMD_GET;
    else                c = CMD_QUERY;
    if (n > 0 && $urandom_range(99) < 85) lo = IDX_W'($urandom_range(n - 1, 0));
    else                                  lo = IDX_W'($urandom);
    if (c == CMD_QUERY && $urandom_range(99) < 70) hi = lo + IDX_W'($urandom_range(40, 0));
    else                                           hi = IDX_W'($urandom);
    case ($urandom_range(19))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = 32'hFFFF_FFFF;
      3:       v = 32'h0;
      default: v = $urandom;
    endcase
    send_request(c, lo, hi, v);
  endtask

  task automatic test_random_traffic(int unsigned items, int unsigned s_pct, int unsigned r_pct,
                                     logic [CNT_W-1:0] count);
    write_leaf_count(count);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (items) random_request();
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    cmd           = CMD_SET;
    index         = '0;
    right_index   = '0;
    value         = '0;
    out_stall     = 1'b0;
    leaf_limit    = 11'd1024;
    send_idle_pct = 37;
    recv_idle_pct = 49;
    for (int k = 0; k < LEAVES; k++) leaf_sums[k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_point_updates();
    test_leaf_count_bounds();
    test_random_traffic(240, 37, 49, 11'd1024);
    test_random_traffic(240, 49, 37, 11'($urandom_range(1023, 1)));
    test_random_traffic(220, 0, 0, 11'd2047);
    wait_for_results();

    $display("Checked %0d results: %0d sets, %0d adds, %0d gets, %0d range queries",
             checked_count, request_count[CMD_SET], request_count[CMD_ADD],
             request_count[CMD_GET], request_count[CMD_QUERY]);
    $display("Leaf counts 0 through 2047, idle and stall on both sides, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
